FILE: hdl/sslp_pkg.sv
`default_nettype none

package sslp_pkg;

  // One accepted byte as seen by the scanners.
  typedef struct packed {
    logic       active;  // byte takes part in the scan (before any NUL)
    logic       clear;   // last byte of the line: return to the idle state afterwards
    logic [7:0] ch;
  } sslp_step_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } sslp_date_t;

  typedef enum logic [1:0] {
    DS_SEARCH = 2'd0,
    DS_READ   = 2'd1,
    DS_DONE   = 2'd2,
    DS_FAIL   = 2'd3
  } date_status_t;

  typedef enum logic [1:0] {
    SP_SPACE  = 2'd0,
    SP_DIGITS = 2'd1,
    SP_DONE   = 2'd2
  } src_phase_t;

  localparam logic [2:0]  SYNC_LEN    = 3'd7;
  localparam logic [2:0]  SRC_FOUND   = 3'd4;
  localparam logic [3:0]  STAMP_LAST  = 4'd15;
  localparam logic [13:0] YEAR_MIN    = 14'd2000;
  localparam logic [13:0] YEAR_MAX    = 14'd2199;
  localparam logic [6:0]  MONTH_MAX   = 7'd12;
  localparam logic [6:0]  DOM_MAX     = 7'd31;
  localparam logic [6:0]  HOUR_MAX    = 7'd23;
  localparam logic [6:0]  MINUTE_MAX  = 7'd59;
  localparam logic [2:0]  SRC_SAT     = 3'd7;
  localparam logic [2:0]  SRC_MAX     = 3'd3;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // "synced="
  function automatic logic [7:0] sync_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = "s";
      3'd1: r = "y";
      3'd2: r = "n";
      3'd3: r = "c";
      3'd4: r = "e";
      3'd5: r = "d";
      3'd6: r = "=";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "src="
  function automatic logic [7:0] src_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = "s";
      2'd1: r = "r";
      2'd2: r = "c";
      default: r = "=";
    endcase
    return r;
  endfunction

  // Stamp template YYYY-MM-DDTHH:MM; zero marks a digit slot.
  function automatic logic [7:0] stamp_char(input logic [3:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd4, 4'd7: r = "-";
      4'd10:      r = "T";
      4'd13:      r = ":";
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sslp_date_scan.sv
`default_nettype none

module sslp_date_scan
  import sslp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sslp_step_t step,
  output sslp_date_t      result
);

  logic [2:0]   sync_cnt_r, sync_cnt_nxt, sync_cnt_upd;
  date_status_t status_r, status_nxt, status_upd;
  logic [3:0]   pos_r, pos_nxt, pos_upd;
  logic [13:0]  year_r, year_nxt, year_upd;
  logic [6:0]   month_r, month_nxt, month_upd;
  logic [6:0]   dom_r, dom_nxt, dom_upd;
  logic [6:0]   hour_r, hour_nxt, hour_upd;
  logic [6:0]   minute_r, minute_nxt, minute_upd;
  logic [3:0]   d;
  logic [7:0]   want;
  logic         ok;

  assign d    = step.ch[3:0];
  assign want = stamp_char(pos_r);

  always_comb begin
    sync_cnt_upd = sync_cnt_r;
    status_upd   = status_r;
    pos_upd      = pos_r;
    year_upd     = year_r;
    month_upd    = month_r;
    dom_upd      = dom_r;
    hour_upd     = hour_r;
    minute_upd   = minute_r;
    if (step.active) begin
      unique case (status_r)
        DS_SEARCH: begin
          if (step.ch == sync_char(sync_cnt_r)) begin
            sync_cnt_upd = sync_cnt_r + 3'd1;
            if (sync_cnt_upd == SYNC_LEN) begin
              status_upd = DS_READ;
              pos_upd    = '0;
            end
          end else begin
            sync_cnt_upd = (step.ch == "s") ? 3'd1 : 3'd0;
          end
        end
        DS_READ: begin
          if (want == 8'h00) begin
            if (!is_digit(step.ch)) begin
              status_upd = DS_FAIL;
            end else begin
              if (pos_r < 4'd4)       year_upd   = 14'(year_r * 14'd10) + {10'd0, d};
              else if (pos_r < 4'd7)  month_upd  = 7'(month_r * 7'd10) + {3'd0, d};
              else if (pos_r < 4'd10) dom_upd    = 7'(dom_r * 7'd10) + {3'd0, d};
              else if (pos_r < 4'd13) hour_upd   = 7'(hour_r * 7'd10) + {3'd0, d};
              else                    minute_upd = 7'(minute_r * 7'd10) + {3'd0, d};
            end
          end else if (step.ch != want) begin
            status_upd = DS_FAIL;
          end
          if (status_upd == DS_READ) begin
            pos_upd = pos_r + 4'd1;
            if (pos_r == STAMP_LAST) status_upd = DS_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Check against the post-byte state so the last byte counts.
  assign ok = (status_upd == DS_DONE) &&
              (year_upd >= YEAR_MIN) && (year_upd <= YEAR_MAX) &&
              (month_upd != 7'd0) && (month_upd <= MONTH_MAX) &&
              (dom_upd != 7'd0) && (dom_upd <= DOM_MAX) &&
              (hour_upd <= HOUR_MAX) && (minute_upd <= MINUTE_MAX);

  always_comb begin
    result              = '0;
    result.ok           = ok;
    if (ok) begin
      result.year         = year_upd[11:0];
      result.month        = month_upd[3:0];
      result.day_of_month = dom_upd[4:0];
      result.hour         = hour_upd[4:0];
      result.minute       = minute_upd[5:0];
    end
  end

  always_comb begin
    if (step.clear) begin
      sync_cnt_nxt = '0;
      status_nxt   = DS_SEARCH;
      pos_nxt      = '0;
      year_nxt     = '0;
      month_nxt    = '0;
      dom_nxt      = '0;
      hour_nxt     = '0;
      minute_nxt   = '0;
    end else begin
      sync_cnt_nxt = sync_cnt_upd;
      status_nxt   = status_upd;
      pos_nxt      = pos_upd;
      year_nxt     = year_upd;
      month_nxt    = month_upd;
      dom_nxt      = dom_upd;
      hour_nxt     = hour_upd;
      minute_nxt   = minute_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cnt_r <= '0;
      status_r   <= DS_SEARCH;
      pos_r      <= '0;
      year_r     <= '0;
      month_r    <= '0;
      dom_r      <= '0;
      hour_r     <= '0;
      minute_r   <= '0;
    end else begin
      sync_cnt_r <= sync_cnt_nxt;
      status_r   <= status_nxt;
      pos_r      <= pos_nxt;
      year_r     <= year_nxt;
      month_r    <= month_nxt;
      dom_r      <= dom_nxt;
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sslp_src_scan.sv
`default_nettype none

module sslp_src_scan
  import sslp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sslp_step_t step,
  output logic [1:0]      source
);

  logic [2:0] match_r, match_nxt, match_upd;
  src_phase_t phase_r, phase_nxt, phase_upd;
  logic [2:0] val_r, val_nxt, val_upd;
  logic       neg_r, neg_nxt, neg_upd;
  logic       take_digit;
  logic [6:0] grown;

  assign grown = 7'({4'd0, val_r} * 7'd10) + {3'd0, step.ch[3:0]};

  always_comb begin
    match_upd  = match_r;
    phase_upd  = phase_r;
    val_upd    = val_r;
    neg_upd    = neg_r;
    take_digit = 1'b0;
    if (step.active) begin
      if (match_r != SRC_FOUND) begin
        if (step.ch == src_char(match_r[1:0])) match_upd = match_r + 3'd1;
        else match_upd = (step.ch == "s") ? 3'd1 : 3'd0;
      end else begin
        unique case (phase_r)
          SP_SPACE: begin
            if (is_space(step.ch)) begin
              phase_upd = SP_SPACE;
            end else if ((step.ch == "+") || (step.ch == "-")) begin
              neg_upd   = (step.ch == "-");
              phase_upd = SP_DIGITS;
            end else if (!is_digit(step.ch)) begin
              phase_upd = SP_DONE;
            end else begin
              phase_upd  = SP_DIGITS;
              take_digit = 1'b1;
            end
          end
          SP_DIGITS: begin
            if (is_digit(step.ch)) take_digit = 1'b1;
            else phase_upd = SP_DONE;
          end
          default: begin
          end
        endcase
        // saturate the magnitude
        if (take_digit) val_upd = (grown > 7'd7) ? SRC_SAT : grown[2:0];
      end
    end
  end

  assign source = ((match_upd == SRC_FOUND) && (val_upd <= SRC_MAX) &&
                   !(neg_upd && (val_upd != 3'd0))) ? val_upd[1:0] : 2'd0;

  always_comb begin
    if (step.clear) begin
      match_nxt = '0;
      phase_nxt = SP_SPACE;
      val_nxt   = '0;
      neg_nxt   = 1'b0;
    end else begin
      match_nxt = match_upd;
      phase_nxt = phase_upd;
      val_nxt   = val_upd;
      neg_nxt   = neg_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
      phase_r <= SP_SPACE;
      val_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      match_r <= match_nxt;
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sync_stamp_line_parser.sv
// Sync stamp line parser.
// Input stream: one text byte per item on in_tdata, in_tlast on the final byte of
// the line. A NUL byte ends the text early; later bytes of the line are ignored
// but in_tlast still closes the line. The first "synced=" must be followed by
// YYYY-MM-DDTHH:MM in range; the first "src=" gives the source (0-3, else 0).
// Output stream: one item per line, sent for the in_tlast byte only. out_tuser
// carries stamp_valid; the date fields and source are zero when it is low.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// A byte lands in the input register when accepted; the line result is loaded
// into the output register when the last byte leaves the input register, which
// waits while the output register holds an item that is not taken.
// Stall: when the output register holds an item that is not taken, the input
// register holds too and in_tready drops once it is full; nothing is lost.
// Reset: synchronous, active low; clears both scanners, the NUL flag and the
// valid bits of both registers. After each line the scanners return to reset.
`default_nettype none

module sync_stamp_line_parser
  import sslp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_line
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [11:0] year, [15:12] month, [20:16] day_of_month,
                                       // [25:21] hour, [31:26] minute, [33:32] source,
                                       // [39:34] zero
  output logic             out_tuser   // [0] stamp_valid
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  // NUL seen in this line
  logic       ended_r, ended_nxt;
  // output register
  logic        out_v_r, out_v_nxt;
  logic [33:0] out_data_r;
  logic        out_user_r;

  logic       advance;
  logic       step_fire;
  sslp_step_t step;
  sslp_date_t date;
  logic [1:0] source;

  // Output slot frees up this cycle: the input register may drain into it.
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign step_fire = in_v_r && advance;

  assign step.active = step_fire && !ended_r && (in_byte_r != 8'h00);
  assign step.clear  = step_fire && in_last_r;
  assign step.ch     = in_byte_r;

  sslp_date_scan u_date (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .result (date)
  );

  sslp_src_scan u_src (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .source (source)
  );

  always_comb begin
    // take a new byte, hold the old one, or go empty
    if (in_tvalid && in_tready) in_v_nxt = 1'b1;
    else if (step_fire)         in_v_nxt = 1'b0;
    else                        in_v_nxt = in_v_r;

    // latch a NUL, drop the flag at end of line
    ended_nxt = ended_r;
    if (step_fire) begin
      if (in_last_r)                  ended_nxt = 1'b0;
      else if (in_byte_r == 8'h00)    ended_nxt = 1'b1;
    end

    // a line result appears only for the last byte
    out_v_nxt = advance ? (in_v_r && in_last_r) : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      ended_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      ended_r <= ended_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step.clear) begin
      out_user_r <= date.ok;
      out_data_r <= {(date.ok ? source : 2'd0), date.minute, date.hour,
                     date.day_of_month, date.month, date.year};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = {6'd0, out_data_r};

  // A byte that is not the last of its line never raises a result.
  a_no_result_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !(in_v_r && in_last_r)) |=> !out_v_r)
    else $error("result raised without an end-of-line byte");

  // An invalid stamp carries all-zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_user_r) |-> (out_data_r == 34'd0))
    else $error("invalid stamp with nonzero fields");

  // A valid stamp is within range.
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_user_r) |->
      ((out_data_r[11:0] >= 12'd2000) && (out_data_r[11:0] <= 12'd2199) &&
       (out_data_r[15:12] != 4'd0) && (out_data_r[15:12] <= 4'd12) &&
       (out_data_r[20:16] != 5'd0) && (out_data_r[25:21] <= 5'd23) &&
       (out_data_r[31:26] <= 6'd59)))
    else $error("valid stamp out of range");

  // The NUL flag never survives into the next line.
  a_nul_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step.clear |=> !ended_r)
    else $error("NUL flag kept past end of line");

endmodule

`default_nettype wire
